[src/bspc_pkg.sv]
// ----------------------------------------------------------------------------
// bspc_pkg
// Types and constants shared by the binary search probe count unit.
// ----------------------------------------------------------------------------
package bspc_pkg;

	localparam int unsigned VAL_W   = 32; // stored value and search key
	localparam int unsigned IDX_W   = 10; // entry index and hit index fields
	localparam int unsigned CNT_W   = 11; // entries_in_use and search bounds
	localparam int unsigned MISS_W  = 4;  // miss probe count
	localparam int unsigned MAX_MISSES = 11;

	typedef enum logic {
		CMD_WRITE  = 1'b0,
		CMD_SEARCH = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_START,
		ST_PROBE,
		ST_FINISH
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic mem_wr;  // store the requested entry
		logic load;    // capture key and bounds of a new search
		logic start;   // issue the first probe
		logic step;    // take the probe result, move the bounds
		logic publish; // move the finished result to the output register
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic range_empty; // bounds already crossed
		logic probe_hit;   // probed entry equals the key
		logic next_empty;  // bounds cross after this miss
		logic out_free;    // output register can take a result
	} dp_sts_t;

endpackage

[src/bspc_if.sv]
// ----------------------------------------------------------------------------
// bspc_req_if / bspc_rsp_if
// Valid/ready channels for requests into and results out of the unit.
// ----------------------------------------------------------------------------
interface bspc_req_if;
	logic               valid;
	logic               ready;
	logic               cmd;
	logic        [9:0]  entry_index;
	logic signed [31:0] entry_value;
	logic signed [31:0] search_key;

	modport source (output valid, cmd, entry_index, entry_value, search_key, input ready);
	modport sink   (input valid, cmd, entry_index, entry_value, search_key, output ready);
endinterface

interface bspc_rsp_if;
	logic       valid;
	logic       ready;
	logic       found;
	logic [9:0] hit_index;
	logic [3:0] miss_probes;

	modport source (output valid, found, hit_index, miss_probes, input ready);
	modport sink   (input valid, found, hit_index, miss_probes, output ready);
endinterface

[src/binary_search_probe_count_unit.sv]
// ----------------------------------------------------------------------------
// binary_search_probe_count_unit
// Sorted-store binary search returning hit flag, index and miss probe count.
// ----------------------------------------------------------------------------
// A write request (cmd 0) stores a value and gives no result; ready stays
// high. A search request (cmd 1) drops ready until its result is in the
// output register: a start step forms the first probe address, one probe
// per cycle follows (at most floor(log2(n)) + 1 probes over n entries, so
// 11 for 1024), and a finish step publishes once the output register is
// free. The probe rate is set by the registered store read feeding the
// compare and bound update that form the next read address. A result
// waiting in the output register does not block further writes.
module binary_search_probe_count_unit
	import bspc_pkg::*;
#(
	parameter int unsigned STORE_DEPTH = 1024
)
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CNT_W-1:0] cfg_wdata,
	bspc_req_if.sink         req,
	bspc_rsp_if.source       rsp
);

	dp_cmd_t dp_cmd;
	dp_sts_t dp_sts;

	bspc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_cmd   (req.cmd),
		.req_ready (req.ready),
		.sts       (dp_sts),
		.cmd       (dp_cmd)
	);

	bspc_dp #(
		.STORE_DEPTH (STORE_DEPTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.entry_index (req.entry_index),
		.entry_value (req.entry_value),
		.search_key  (req.search_key),
		.cmd         (dp_cmd),
		.sts         (dp_sts),
		.rsp         (rsp)
	);

endmodule

[src/bspc_ctrl.sv]
// ----------------------------------------------------------------------------
// bspc_ctrl
// Search sequencer: accepts requests, steps the probes, hands off the result.
// ----------------------------------------------------------------------------
module bspc_ctrl
	import bspc_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    req_valid,
	input  logic    req_cmd,
	output logic    req_ready,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	state_t state_q;
	state_t state_nx;
	logic   req_fire;

	assign req_fire = req_valid && req_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_fire && (req_cmd == CMD_SEARCH)) begin
					state_nx = ST_START;
				end
			end
			ST_START: begin
				state_nx = sts.range_empty ? ST_FINISH : ST_PROBE;
			end
			ST_PROBE: begin
				if (sts.probe_hit || sts.next_empty) begin
					state_nx = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (sts.out_free) begin
					state_nx = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		req_ready   = 1'b0;
		cmd         = '0;
		case (state_q)
			ST_IDLE: begin
				req_ready  = 1'b1;
				cmd.mem_wr = req_valid && (req_cmd == CMD_WRITE);
				cmd.load   = req_valid && (req_cmd == CMD_SEARCH);
			end
			ST_START:  cmd.start   = !sts.range_empty;
			ST_PROBE:  cmd.step    = 1'b1;
			ST_FINISH: cmd.publish = sts.out_free;
			default: begin
				req_ready = 1'b0;
			end
		endcase
	end

endmodule

[src/bspc_dp.sv]
// ----------------------------------------------------------------------------
// bspc_dp
// Sorted store, search bounds, probe compare and the result register.
// ----------------------------------------------------------------------------
module bspc_dp
	import bspc_pkg::*;
#(
	parameter int unsigned STORE_DEPTH = 1024
)
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic        [CNT_W-1:0] cfg_wdata,
	input  logic        [IDX_W-1:0] entry_index,
	input  logic signed [VAL_W-1:0] entry_value,
	input  logic signed [VAL_W-1:0] search_key,
	input  dp_cmd_t                 cmd,
	output dp_sts_t                 sts,
	bspc_rsp_if.source              rsp
);

	localparam int unsigned AW = $clog2(STORE_DEPTH);

	logic signed [VAL_W-1:0] mem [STORE_DEPTH];

	logic        [CNT_W-1:0]  entries_q;
	logic signed [VAL_W-1:0]  key_q;
	logic        [CNT_W-1:0]  lo_q;
	logic        [CNT_W-1:0]  hx_q;    // one past the upper bound
	logic        [CNT_W-1:0]  mid_q;
	logic        [MISS_W-1:0] miss_q;
	logic                     found_q;
	logic        [IDX_W-1:0]  hit_q;
	logic signed [VAL_W-1:0]  rd_data_q;
	logic                     out_valid_q;
	logic                     out_found_q;
	logic        [IDX_W-1:0]  out_hit_q;
	logic        [MISS_W-1:0] out_miss_q;

	logic [CNT_W-1:0] n_sat;
	logic [CNT_W:0]   sum_start;
	logic [CNT_W-1:0] mid_start;
	logic             key_lt;
	logic [CNT_W-1:0] lo_nx;
	logic [CNT_W-1:0] hx_nx;
	logic [CNT_W:0]   sum_nx;
	logic [CNT_W-1:0] mid_nx;
	logic [AW-1:0]    rd_addr;
	logic             wr_in_range;

	// clamp the range to the store
	assign n_sat = (32'(entries_q) > STORE_DEPTH) ? CNT_W'(STORE_DEPTH) : entries_q;

	assign sum_start = {1'b0, lo_q} + {1'b0, hx_q} - (CNT_W+1)'(1);
	assign mid_start = sum_start[CNT_W:1];

	assign key_lt = key_q < rd_data_q;
	assign lo_nx  = key_lt ? lo_q : mid_q + CNT_W'(1);
	assign hx_nx  = key_lt ? mid_q : hx_q;
	assign sum_nx = {1'b0, lo_nx} + {1'b0, hx_nx} - (CNT_W+1)'(1);
	assign mid_nx = sum_nx[CNT_W:1];

	assign rd_addr     = cmd.step ? AW'(mid_nx) : AW'(mid_start);
	assign wr_in_range = 32'(entry_index) < STORE_DEPTH;

	assign sts.range_empty = lo_q >= hx_q;
	assign sts.probe_hit   = rd_data_q == key_q;
	assign sts.next_empty  = lo_nx >= hx_nx;
	assign sts.out_free    = !out_valid_q || rsp.ready;

	always_ff @(posedge clk) begin
		if (cmd.mem_wr && wr_in_range) begin
			mem[AW'(entry_index)] <= entry_value;
		end
		rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entries_q <= '0;
		end else if (cfg_we) begin
			entries_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			key_q   <= search_key;
			lo_q    <= '0;
			hx_q    <= n_sat;
			miss_q  <= '0;
			found_q <= 1'b0;
			hit_q   <= '0;
		end
		if (cmd.start) begin
			mid_q <= mid_start;
		end
		if (cmd.step) begin
			if (sts.probe_hit) begin
				found_q <= 1'b1;
				hit_q   <= IDX_W'(mid_q);
			end else begin
				lo_q   <= lo_nx;
				hx_q   <= hx_nx;
				mid_q  <= mid_nx;
				miss_q <= miss_q + MISS_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.publish) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.publish) begin
			out_found_q <= found_q;
			out_hit_q   <= hit_q;
			out_miss_q  <= miss_q;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.found       = out_found_q;
	assign rsp.hit_index   = out_hit_q;
	assign rsp.miss_probes = out_miss_q;

endmodule

[src/bspc_chk.sv]
// ----------------------------------------------------------------------------
// bspc_chk
// Port-level checks on the binary search probe count unit.
// ----------------------------------------------------------------------------
module bspc_chk
	import bspc_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              req_valid,
	input logic              req_ready,
	input logic              req_cmd,
	input logic              rsp_valid,
	input logic              rsp_ready,
	input logic              rsp_found,
	input logic [IDX_W-1:0]  rsp_hit_index,
	input logic [MISS_W-1:0] rsp_miss_probes
);

	logic req_fire;

	assign req_fire = req_valid && req_ready;

	// a search holds off further requests while it runs
	a_search_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_fire && (req_cmd == CMD_SEARCH) |=> !req_ready)
		else $error("request taken during a running search");

	// a write never stalls the request side
	a_write_free: assert property (@(posedge clk) disable iff (!arst_n)
		req_fire && (req_cmd == CMD_WRITE) |=> req_ready)
		else $error("write request dropped ready");

	a_miss_index: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_found |-> rsp_hit_index == '0)
		else $error("non-zero hit index on a miss");

	a_miss_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> 32'(rsp_miss_probes) <= MAX_MISSES)
		else $error("miss probe count out of range");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_found)
			&& $stable(rsp_hit_index) && $stable(rsp_miss_probes))
		else $error("stalled result changed");

endmodule

bind binary_search_probe_count_unit bspc_chk u_bspc_chk (
	.clk             (clk),
	.arst_n          (arst_n),
	.req_valid       (req.valid),
	.req_ready       (req.ready),
	.req_cmd         (req.cmd),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.rsp_found       (rsp.found),
	.rsp_hit_index   (rsp.hit_index),
	.rsp_miss_probes (rsp.miss_probes)
);
